// ===== hw/rtl/kmer_cdf_rank_predictor_unit_assert.svh =====
// ----------------------------------------------------------------------------
// kmer_cdf_rank_predictor_unit assertion macros
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef KMER_CDF_RANK_PREDICTOR_UNIT_ASSERT_SVH
`define KMER_CDF_RANK_PREDICTOR_UNIT_ASSERT_SVH

// ante holds -> cons holds in the same cycle
`define KCRP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("kcrp: implication check failed");

// ante holds -> cons holds in the next cycle
`define KCRP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("kcrp: next-cycle check failed");

`endif

// ===== hw/rtl/kcrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcrp_pkg
// Shared widths, codes and payload types of the k-mer CDF rank predictor.
// ----------------------------------------------------------------------------
package kcrp_pkg;

  localparam int ROW_W      = 41;
  localparam int BIAS_W     = 32;
  localparam int SCALE_W    = 48;
  localparam int CODE_W     = 42;
  localparam int UIDX_W     = 6;
  localparam int WGT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  // shared multiplier: 33x33 signed, so a 32-bit unsigned chunk fits
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  localparam int DEF_HIDDEN_UNITS = 64;
  localparam int DEF_KMER_BASES   = 21;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_PREDICT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_TOTAL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_BIAS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESID_SCALE = 2'd2;

  localparam logic [ROW_W-1:0]   ROW_TOTAL_RST   = 41'd1;
  localparam logic [BIAS_W-1:0]  OUT_BIAS_RST    = 32'd0;
  localparam logic [SCALE_W-1:0] RESID_SCALE_RST = 48'd65536;

  typedef struct packed {
    logic                    func;
    logic [UIDX_W-1:0]       unit_index;
    logic signed [WGT_W-1:0] hid_weight;
    logic signed [WGT_W-1:0] hid_bias;
    logic signed [WGT_W-1:0] out_weight;
    logic [CODE_W-1:0]       kmer_code;
  } kcrp_in_t;

  typedef struct packed {
    logic [ROW_W-1:0] predicted_row;
    logic             clamp_hit;
  } kcrp_out_t;

endpackage

// ===== hw/rtl/kcrp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcrp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kcrp_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/kcrp_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcrp_mul
// Shared signed 33x33 multiplier with a registered product.
// ----------------------------------------------------------------------------
module kcrp_mul import kcrp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [MUL_W-1:0]  a_i,
  input  logic signed [MUL_W-1:0]  b_i,
  output logic signed [PROD_W-1:0] p_o
);

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

// ===== hw/rtl/kmer_cdf_rank_predictor_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmer_cdf_rank_predictor_unit
// Learned-index rank predictor: one-hidden-layer ReLU model over a k-mer code.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes load and predict
//   transactions. A load writes one hidden unit's weights into the weight RAM
//   and leaves the sequencer idle; it returns nothing. A predict runs the model and
//   returns one result transaction on the output channel.
//   A predict steps the sequencer through every hidden unit, then the tail,
//   align and output states. The next transaction is taken only once the
//   sequencer is back in idle, so predicts do not overlap. The sequence is
//   set by the single shared 33x33 multiplier: three products per hidden
//   unit plus a sum step, then ten partial products for the residual scale
//   and the baseline.
//   The result sits in an output register; while it waits under out_stall_i
//   the block still accepts and works on the next transaction, and only the
//   final write of a new result waits for the register to drain.
//   Configuration (cfg_valid_i / cfg_ready_o) is always ready; write it only
//   while no transaction is in flight.
//   Reset clears the sequencer and the output valid and sets the
//   configuration registers to their defaults. The weight RAM is not
//   cleared: load every hidden unit before the first predict.
// ----------------------------------------------------------------------------
`include "kmer_cdf_rank_predictor_unit_assert.svh"

module kmer_cdf_rank_predictor_unit import kcrp_pkg::*; #(
  parameter int HIDDEN_UNITS = DEF_HIDDEN_UNITS,
  parameter int KMER_BASES   = DEF_KMER_BASES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  kcrp_in_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output kcrp_out_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int F      = 2 * KMER_BASES;
  localparam int UW     = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
  localparam int PRE_W  = (((F + 32) > 74) ? (F + 32) : 74) + 1;
  localparam int ACC_W  = 65 + $clog2(HIDDEN_UNITS + 1);
  localparam int TOT_W  = (((ACC_W + 48) > 90) ? (ACC_W + 48) : 90) + 2;
  localparam int BASE_W = 84;
  localparam int SH_L   = (F <= 48) ? (48 - F) : 0;
  localparam int SH_R   = (F > 48) ? (F - 48) : 0;
  localparam int MEM_W  = 3 * WGT_W;

  localparam logic [CODE_W-1:0] KEY_MASK =
    (F >= CODE_W) ? '1 : CODE_W'((64'd1 << F) - 64'd1);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_UA    = 4'd1;
  localparam logic [3:0] S_UB    = 4'd2;
  localparam logic [3:0] S_UC    = 4'd3;
  localparam logic [3:0] S_UD    = 4'd4;
  localparam logic [3:0] S_ACC   = 4'd5;
  localparam logic [3:0] S_TAIL  = 4'd6;
  localparam logic [3:0] S_TLAST = 4'd7;
  localparam logic [3:0] S_ALIGN = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  // tail partial products: accumulator chunk x scale half, key x slope half
  localparam logic [3:0] T_A0_SLO = 4'd0;
  localparam logic [3:0] T_A0_SHI = 4'd1;
  localparam logic [3:0] T_A1_SLO = 4'd2;
  localparam logic [3:0] T_A1_SHI = 4'd3;
  localparam logic [3:0] T_A2_SLO = 4'd4;
  localparam logic [3:0] T_A2_SHI = 4'd5;
  localparam logic [3:0] T_K0_RLO = 4'd6;
  localparam logic [3:0] T_K0_RHI = 4'd7;
  localparam logic [3:0] T_K1_RLO = 4'd8;
  localparam logic [3:0] T_K1_RHI = 4'd9;

  localparam logic signed [TOT_W-1:0] UNITY = TOT_W'(1) <<< 48;
  localparam logic signed [TOT_W-1:0] HALF  = TOT_W'(1) <<< 47;

  logic [3:0]                state_q, state_d;
  logic [UW-1:0]             unit_q, unit_d;
  logic [3:0]                tstep_q, tstep_d;
  logic [3:0]                tsel_q, tsel_d;
  logic                      tpend_q, tpend_d;
  logic [CODE_W-1:0]         key_q, key_d;
  logic [ROW_W-1:0]          slope_q, slope_d;
  logic signed [PRE_W-1:0]   pre_q, pre_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [TOT_W-1:0]   res_q, res_d;
  logic signed [BASE_W-1:0]  base_q, base_d;
  logic                      out_valid_q, out_valid_d;
  kcrp_out_t                 out_data_q, out_data_d;
  logic [ROW_W-1:0]          row_total_q;
  logic [BIAS_W-1:0]         out_bias_q;
  logic [SCALE_W-1:0]        resid_scale_q;

  logic                      in_acc;
  logic [8:0]                load_idx;
  logic                      ram_we, ram_re;
  logic [UW-1:0]             ram_raddr;
  logic [MEM_W-1:0]          ram_rdata;
  logic signed [WGT_W-1:0]   w_w, w_b, w_v;
  logic                      mul_en;
  logic signed [MUL_W-1:0]   op_a, op_b;
  logic signed [PROD_W-1:0]  prod;
  logic [6:0]                tail_sh;
  logic                      tail_to_base;
  logic signed [TOT_W-1:0]   aligned_base;
  logic signed [TOT_W-1:0]   limit;
  logic signed [TOT_W-1:0]   rounded;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign load_idx    = {3'b000, in_data_i.unit_index};
  assign ram_we      = in_acc && (in_data_i.func == FUNC_LOAD) &&
                       (load_idx < 9'(HIDDEN_UNITS));

  kcrp_ram #(
    .WIDTH  (MEM_W),
    .DEPTH  (HIDDEN_UNITS),
    .ADDR_W (UW)
  ) u_wgt_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (load_idx[UW-1:0]),
    .wdata_i ({in_data_i.hid_weight, in_data_i.hid_bias, in_data_i.out_weight}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign w_w = ram_rdata[3*WGT_W-1:2*WGT_W];
  assign w_b = ram_rdata[2*WGT_W-1:WGT_W];
  assign w_v = ram_rdata[WGT_W-1:0];

  assign mul_en = (state_q != S_IDLE);

  kcrp_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (op_a),
    .b_i   (op_b),
    .p_o   (prod)
  );

  // multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_q)
      S_UA: begin
        op_a = {1'b0, key_q[31:0]};
        op_b = MUL_W'(w_w);
      end
      S_UB: begin
        op_a = {23'd0, key_q[CODE_W-1:32]};
        op_b = MUL_W'(w_w);
      end
      S_UD: begin
        // ReLU: a negative pre-activation contributes nothing
        op_a = pre_q[PRE_W-1] ? '0 : {1'b0, pre_q[F +: 32]};
        op_b = MUL_W'(w_v);
      end
      S_TAIL: begin
        unique case (tstep_q)
          T_A0_SLO: begin
            op_a = {1'b0, acc_q[31:0]};
            op_b = {1'b0, resid_scale_q[31:0]};
          end
          T_A0_SHI: begin
            op_a = {1'b0, acc_q[31:0]};
            op_b = MUL_W'($signed(resid_scale_q[SCALE_W-1:32]));
          end
          T_A1_SLO: begin
            op_a = {1'b0, acc_q[63:32]};
            op_b = {1'b0, resid_scale_q[31:0]};
          end
          T_A1_SHI: begin
            op_a = {1'b0, acc_q[63:32]};
            op_b = MUL_W'($signed(resid_scale_q[SCALE_W-1:32]));
          end
          T_A2_SLO: begin
            op_a = MUL_W'($signed(acc_q[ACC_W-1:64]));
            op_b = {1'b0, resid_scale_q[31:0]};
          end
          T_A2_SHI: begin
            op_a = MUL_W'($signed(acc_q[ACC_W-1:64]));
            op_b = MUL_W'($signed(resid_scale_q[SCALE_W-1:32]));
          end
          T_K0_RLO: begin
            op_a = {1'b0, key_q[31:0]};
            op_b = {1'b0, slope_q[31:0]};
          end
          T_K0_RHI: begin
            op_a = {1'b0, key_q[31:0]};
            op_b = {24'd0, slope_q[ROW_W-1:32]};
          end
          T_K1_RLO: begin
            op_a = {23'd0, key_q[CODE_W-1:32]};
            op_b = {1'b0, slope_q[31:0]};
          end
          T_K1_RHI: begin
            op_a = {23'd0, key_q[CODE_W-1:32]};
            op_b = {24'd0, slope_q[ROW_W-1:32]};
          end
          default: begin
            op_a = '0;
            op_b = '0;
          end
        endcase
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // weight of the partial product now sitting in the multiplier register
  always_comb begin
    tail_sh      = 7'd0;
    tail_to_base = 1'b0;
    unique case (tsel_q) inside
      T_A0_SLO:           tail_sh = 7'd0;
      T_A0_SHI, T_A1_SLO: tail_sh = 7'd32;
      T_A1_SHI, T_A2_SLO: tail_sh = 7'd64;
      T_A2_SHI:           tail_sh = 7'd96;
      T_K0_RLO: begin
        tail_sh      = 7'd0;
        tail_to_base = 1'b1;
      end
      T_K0_RHI, T_K1_RLO: begin
        tail_sh      = 7'd32;
        tail_to_base = 1'b1;
      end
      T_K1_RHI: begin
        tail_sh      = 7'd64;
        tail_to_base = 1'b1;
      end
      default: begin
        tail_sh      = 7'd0;
        tail_to_base = 1'b0;
      end
    endcase
  end

  // baseline brought to 48 fraction bits (floored when the code is finer)
  assign aligned_base = (F <= 48) ? (TOT_W'(base_q) <<< SH_L)
                                  : (TOT_W'(base_q) >>> SH_R);
  assign limit   = TOT_W'($signed({1'b0, row_total_q})) <<< 48;
  assign rounded = res_q + HALF;

  always_comb begin
    state_d     = state_q;
    unit_d      = unit_q;
    tstep_d     = tstep_q;
    tsel_d      = tsel_q;
    tpend_d     = tpend_q;
    key_d       = key_q;
    slope_d     = slope_q;
    pre_d       = pre_q;
    acc_d       = acc_q;
    res_d       = res_q;
    base_d      = base_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    ram_re      = 1'b0;
    ram_raddr   = unit_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (in_data_i.func == FUNC_PREDICT)) begin
          key_d     = in_data_i.kmer_code & KEY_MASK;
          slope_d   = (row_total_q == '0) ? '0 : row_total_q - ROW_W'(1);
          acc_d     = ACC_W'($signed(out_bias_q)) <<< 16;
          unit_d    = '0;
          ram_re    = 1'b1;
          ram_raddr = '0;
          state_d   = S_UA;
        end
      end
      S_UA: begin
        // product of the previous unit's activation and output weight
        if (unit_q != '0) begin
          acc_d = acc_q + ACC_W'(prod);
        end
        state_d = S_UB;
      end
      S_UB: begin
        pre_d   = (PRE_W'(w_b) <<< F) + PRE_W'(prod);
        state_d = S_UC;
      end
      S_UC: begin
        pre_d   = pre_q + (PRE_W'(prod) <<< 32);
        state_d = S_UD;
      end
      S_UD: begin
        if (unit_q == UW'(HIDDEN_UNITS - 1)) begin
          state_d = S_ACC;
        end else begin
          unit_d    = unit_q + UW'(1);
          ram_re    = 1'b1;
          ram_raddr = unit_q + UW'(1);
          state_d   = S_UA;
        end
      end
      S_ACC: begin
        acc_d   = acc_q + ACC_W'(prod);
        res_d   = UNITY;
        base_d  = '0;
        tstep_d = T_A0_SLO;
        tpend_d = 1'b0;
        state_d = S_TAIL;
      end
      S_TAIL, S_TLAST: begin
        if (tpend_q) begin
          if (tail_to_base) begin
            base_d = base_q + (BASE_W'(prod) <<< tail_sh);
          end else begin
            res_d = res_q + (TOT_W'(prod) <<< tail_sh);
          end
        end
        if (state_q == S_TAIL) begin
          tsel_d  = tstep_q;
          tpend_d = 1'b1;
          tstep_d = tstep_q + 4'd1;
          if (tstep_q == T_K1_RHI) begin
            state_d = S_TLAST;
          end
        end else begin
          tpend_d = 1'b0;
          state_d = S_ALIGN;
        end
      end
      S_ALIGN: begin
        res_d   = res_q + aligned_base;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          if (res_q[TOT_W-1]) begin
            out_data_d.predicted_row = '0;
            out_data_d.clamp_hit     = 1'b1;
          end else if (res_q > limit) begin
            out_data_d.predicted_row = row_total_q;
            out_data_d.clamp_hit     = 1'b1;
          end else begin
            out_data_d.predicted_row = rounded[48 +: ROW_W];
            out_data_d.clamp_hit     = 1'b0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      unit_q        <= '0;
      tstep_q       <= T_A0_SLO;
      tsel_q        <= T_A0_SLO;
      tpend_q       <= 1'b0;
      out_valid_q   <= 1'b0;
      row_total_q   <= ROW_TOTAL_RST;
      out_bias_q    <= OUT_BIAS_RST;
      resid_scale_q <= RESID_SCALE_RST;
    end else begin
      state_q     <= state_d;
      unit_q      <= unit_d;
      tstep_q     <= tstep_d;
      tsel_q      <= tsel_d;
      tpend_q     <= tpend_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_ROW_TOTAL:   row_total_q   <= cfg_data_i[ROW_W-1:0];
          CFG_OUT_BIAS:    out_bias_q    <= cfg_data_i[BIAS_W-1:0];
          CFG_RESID_SCALE: resid_scale_q <= cfg_data_i[SCALE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    slope_q    <= slope_d;
    pre_q      <= pre_d;
    acc_q      <= acc_d;
    res_q      <= res_d;
    base_q     <= base_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `KCRP_ASSERT_NXT(a_predict_starts, clk_i, rst_ni, in_acc && (in_data_i.func == FUNC_PREDICT), state_q == S_UA)
  `KCRP_ASSERT_NXT(a_load_one_cycle, clk_i, rst_ni, in_acc && (in_data_i.func == FUNC_LOAD), state_q == S_IDLE)
  `KCRP_ASSERT_IMP(a_row_in_range, clk_i, rst_ni, out_valid_q && !out_data_q.clamp_hit, out_data_q.predicted_row <= row_total_q)
  `KCRP_ASSERT_IMP(a_clamp_at_end, clk_i, rst_ni, out_valid_q && out_data_q.clamp_hit, (out_data_q.predicted_row == '0) || (out_data_q.predicted_row == row_total_q))

endmodule
